[sv/prcd_pkg.sv]
// Shared types, constants and register codes for the pixel row change detector.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package prcd_pkg;

    // Field widths fixed by the interface
    localparam int PIX_W   = 8;
    localparam int ROW_W   = 12;
    localparam int LEN_W   = 7;
    localparam int THR_W   = 8;
    localparam int STEP_W  = 7;
    localparam int MREQ_W  = 13;
    localparam int CFG_W   = 13;

    // Default sizing of the block
    localparam int MAX_WINDOW_DEF = 64;
    localparam int MAX_WIDTH_DEF  = 4096;

    // Register values after reset
    localparam logic [LEN_W-1:0]  RESET_WINDOW_LENGTH    = 7'd8;
    localparam logic [THR_W-1:0]  RESET_DIFF_THRESHOLD   = 8'd3;
    localparam logic [STEP_W-1:0] RESET_STEP_SIZE        = 7'd1;
    localparam logic [MREQ_W-1:0] RESET_MATCHES_REQUIRED = 13'd11;

    // Match count saturates at its all-ones value
    localparam logic [MREQ_W-1:0] MATCH_MAX = '1;

    // Queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_WINDOW_LENGTH,
        CFG_DIFF_THRESHOLD,
        CFG_STEP_SIZE,
        CFG_MATCHES_REQUIRED
    } cfg_index_t;

    // Sequencer of the column phase unit
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_COL,
        PH_LEN
    } phase_state_t;

    // One classified pixel handed from the front to the back part
    typedef struct packed {
        logic             win_match;
        logic             last;
        logic             scan;
        logic [ROW_W-1:0] row;
    } entry_t;

    // Column events from the front part to the phase unit
    typedef struct packed {
        logic adv;
        logic clr;
    } col_evt_t;

    // Phase unit status
    typedef struct packed {
        logic busy;
        logic hit;
    } phase_stat_t;

    // Queue fill status
    typedef struct packed {
        logic full;
        logic almost_full;
    } queue_stat_t;

endpackage

`default_nettype wire

[sv/prcd_phase.sv]
// Column phase unit: keeps column mod step and window length mod step.
// After a length or step write it recomputes both with a bit-serial remainder.
// Depends on prcd_pkg.
`default_nettype none

module prcd_phase #(
    parameter int MAX_WINDOW = prcd_pkg::MAX_WINDOW_DEF,
    parameter int MAX_WIDTH  = prcd_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_touch,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]       col_i,
    input  wire logic [$clog2(MAX_WINDOW+1)-1:0]      eff_len_i,
    input  wire logic [prcd_pkg::STEP_W-1:0]          eff_step_i,
    input  wire prcd_pkg::col_evt_t                   evt_i,
    output prcd_pkg::phase_stat_t                     stat_o
);

    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int LENW = $clog2(MAX_WINDOW + 1);
    localparam int DW   = (CW > LENW) ? CW : LENW;
    localparam int NW   = $clog2(DW);
    localparam int SW   = prcd_pkg::STEP_W;
    localparam int RESET_LEN_EFF = (MAX_WINDOW < 8) ? MAX_WINDOW : 8;
    localparam int RESET_RL      = RESET_LEN_EFF % 1;

    prcd_pkg::phase_state_t state_reg, state_next;

    logic [DW-1:0] div_reg;
    logic [SW-1:0] rem_reg;
    logic [NW-1:0] cnt_reg;
    logic [SW-1:0] rc_reg;
    logic [SW-1:0] rl_reg;

    logic [SW:0]   trial;
    logic [SW-1:0] rem_new;
    logic          last_bit;
    logic [SW:0]   rc_inc;

    // One restoring remainder step per cycle
    always_comb begin
        trial    = {rem_reg, div_reg[DW-1]};
        rem_new  = (trial >= {1'b0, eff_step_i}) ? SW'(trial - {1'b0, eff_step_i})
                                                 : trial[SW-1:0];
        last_bit = (cnt_reg == NW'(DW - 1));
        rc_inc   = {1'b0, rc_reg} + {{SW{1'b0}}, 1'b1};
    end

    // Sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= prcd_pkg::PH_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencer: a column pass, then a length pass; a new write restarts it.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            prcd_pkg::PH_IDLE: begin
                if (cfg_touch) state_next = prcd_pkg::PH_COL;
            end
            prcd_pkg::PH_COL: begin
                if (cfg_touch) state_next = prcd_pkg::PH_COL;
                else if (last_bit) state_next = prcd_pkg::PH_LEN;
            end
            prcd_pkg::PH_LEN: begin
                if (cfg_touch) state_next = prcd_pkg::PH_COL;
                else if (last_bit) state_next = prcd_pkg::PH_IDLE;
            end
            default: state_next = prcd_pkg::PH_IDLE;
        endcase
    end

    // Remainder datapath and the phase registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rc_reg <= '0;
            rl_reg <= SW'(RESET_RL);
        end else if (cfg_touch) begin
            div_reg <= DW'(col_i);
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (state_reg != prcd_pkg::PH_IDLE) begin
            rem_reg <= rem_new;
            div_reg <= div_reg << 1;
            cnt_reg <= cnt_reg + 1'b1;
            if (last_bit) begin
                rem_reg <= '0;
                cnt_reg <= '0;
                if (state_reg == prcd_pkg::PH_COL) begin
                    rc_reg  <= rem_new;
                    div_reg <= DW'(eff_len_i);
                end else begin
                    rl_reg <= rem_new;
                end
            end
        end else if (evt_i.clr) begin
            rc_reg <= '0;
        end else if (evt_i.adv) begin
            rc_reg <= (rc_inc == {1'b0, eff_step_i}) ? '0 : rc_inc[SW-1:0];
        end
    end

    assign stat_o.busy = (state_reg != prcd_pkg::PH_IDLE);
    assign stat_o.hit  = (rc_reg == rl_reg);

endmodule

`default_nettype wire

[sv/prcd_front.sv]
// Front part: accepts pixel transfers, keeps per-row prefix sums of the channel
// differences in a ring memory and judges each completed window at a step position.
// Depends on prcd_pkg.
`default_nettype none

module prcd_front #(
    parameter int MAX_WINDOW = prcd_pkg::MAX_WINDOW_DEF,
    parameter int MAX_WIDTH  = prcd_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [prcd_pkg::PIX_W-1:0]          s_new_blue,
    input  wire logic [prcd_pkg::PIX_W-1:0]          s_new_green,
    input  wire logic [prcd_pkg::PIX_W-1:0]          s_new_red,
    input  wire logic [prcd_pkg::PIX_W-1:0]          s_old_blue,
    input  wire logic [prcd_pkg::PIX_W-1:0]          s_old_green,
    input  wire logic [prcd_pkg::PIX_W-1:0]          s_old_red,
    input  wire logic [prcd_pkg::ROW_W-1:0]          s_row_index,
    input  wire logic                                s_start_of_scan,
    input  wire logic                                s_last_in_row,
    input  wire logic [$clog2(MAX_WINDOW+1)-1:0]     eff_len_i,
    input  wire logic [prcd_pkg::THR_W-1:0]          thr_i,
    input  wire prcd_pkg::phase_stat_t               phase_stat_i,
    input  wire prcd_pkg::queue_stat_t               q_stat_i,
    output logic [$clog2(MAX_WIDTH+1)-1:0]           col_o,
    output prcd_pkg::col_evt_t                       evt_o,
    output logic                                     push_o,
    output prcd_pkg::entry_t                         push_entry_o
);

    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int LENW = $clog2(MAX_WINDOW + 1);
    localparam int XW   = (CW > LENW) ? CW : LENW;
    localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int DEPTH = 1 << AW;
    localparam int SW   = $clog2(MAX_WINDOW * 255 + 1) + 1;
    localparam int LW   = LENW + prcd_pkg::THR_W;
    localparam int CMPW = SW + LW;
    localparam int PW   = prcd_pkg::PIX_W;

    logic [CW-1:0]         col_reg;
    logic [2:0][SW-1:0]    pref_reg;
    logic [2:0][SW-1:0]    pref_next;
    logic [3*SW-1:0]       ring_mem [DEPTH];
    logic [3*SW-1:0]       rd_reg;
    logic [3*SW-1:0]       pcur_reg;
    logic                  st1_valid_reg;
    logic                  win_reg;
    logic                  last_reg;
    logic                  scan_reg;
    logic [prcd_pkg::ROW_W-1:0] row_reg;
    logic [LW-1:0]         limit_reg;

    logic                  accept;
    logic                  in_range;
    logic                  win;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [2:0][PW-1:0]    new_px;
    logic [2:0][PW-1:0]    old_px;
    logic [2:0][PW:0]      diff;
    logic [2:0][SW-1:0]    wsum;
    logic [2:0][SW-1:0]    mag;
    logic                  match;

    // Input handshake: no phase recompute, and the queue must hold this pixel and the one in flight.
    assign s_ready = !phase_stat_i.busy &&
                     !(st1_valid_reg ? q_stat_i.almost_full : q_stat_i.full);
    assign accept  = s_valid && s_ready;

    // Classify the incoming pixel and form the next prefix sums
    always_comb begin
        new_px   = {s_new_red, s_new_green, s_new_blue};
        old_px   = {s_old_red, s_old_green, s_old_blue};
        in_range = (col_reg < CW'(MAX_WIDTH));
        win      = in_range && (XW'(col_reg) >= XW'(eff_len_i)) && phase_stat_i.hit;
        wr_addr  = AW'(col_reg);
        rd_addr  = AW'(col_reg) - AW'(eff_len_i);
        for (int c = 0; c < 3; c++) begin
            diff[c]      = {1'b0, new_px[c]} - {1'b0, old_px[c]};
            pref_next[c] = pref_reg[c] + SW'($signed(diff[c]));
        end
    end

    // Column counter and running prefix sums
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            pref_reg      <= '0;
            st1_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= accept;
            if (accept) begin
                if (s_last_in_row) begin
                    col_reg  <= '0;
                    pref_reg <= '0;
                end else if (in_range) begin
                    col_reg  <= col_reg + 1'b1;
                    pref_reg <= pref_next;
                end
            end
        end
    end

    // Prefix ring: slot holds the prefix before that column; read is registered.
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (in_range) begin
                ring_mem[wr_addr] <= pref_reg;
            end
            rd_reg <= ring_mem[rd_addr];
        end
    end

    // Stage one payload and the comparison limit
    always_ff @(posedge aclk) begin
        if (accept) begin
            pcur_reg <= pref_reg;
            win_reg  <= win;
            last_reg <= s_last_in_row;
            scan_reg <= s_start_of_scan;
            row_reg  <= s_row_index;
        end
        limit_reg <= LW'(eff_len_i) * LW'(thr_i);
    end

    // Window sums from prefix differences, then the magnitude compare
    always_comb begin
        match = 1'b0;
        for (int c = 0; c < 3; c++) begin
            wsum[c] = pcur_reg[c*SW +: SW] - rd_reg[c*SW +: SW];
            mag[c]  = wsum[c][SW-1] ? (~wsum[c] + SW'(1)) : wsum[c];
            if (CMPW'(mag[c]) > CMPW'(limit_reg)) match = 1'b1;
        end
    end

    assign col_o     = col_reg;
    assign evt_o.adv = accept && in_range;
    assign evt_o.clr = accept && s_last_in_row;

    assign push_o                 = st1_valid_reg;
    assign push_entry_o.win_match = win_reg && match;
    assign push_entry_o.last      = last_reg;
    assign push_entry_o.scan      = scan_reg;
    assign push_entry_o.row       = row_reg;

endmodule

`default_nettype wire

[sv/prcd_queue.sv]
// Short queue of classified pixels between the front and back parts.
// Depends on prcd_pkg.
`default_nettype none

module prcd_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push_i,
    input  wire prcd_pkg::entry_t      push_entry_i,
    input  wire logic                  pop_i,
    output logic                       head_valid_o,
    output prcd_pkg::entry_t           head_o,
    output prcd_pkg::queue_stat_t      stat_o
);

    localparam int QAW = prcd_pkg::QUEUE_AW;
    localparam int QCW = prcd_pkg::QUEUE_CW;

    prcd_pkg::entry_t  slot_reg [prcd_pkg::QUEUE_DEPTH];
    logic [QAW-1:0]    wr_ptr_reg;
    logic [QAW-1:0]    rd_ptr_reg;
    logic [QCW-1:0]    count_reg;

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_i) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop_i)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push_i && !pop_i)      count_reg <= count_reg + 1'b1;
            else if (pop_i && !push_i) count_reg <= count_reg - 1'b1;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push_i) slot_reg[wr_ptr_reg] <= push_entry_i;
    end

    assign head_valid_o       = (count_reg != '0);
    assign head_o             = slot_reg[rd_ptr_reg];
    assign stat_o.full        = (count_reg == QCW'(prcd_pkg::QUEUE_DEPTH));
    assign stat_o.almost_full = (count_reg >= QCW'(prcd_pkg::QUEUE_DEPTH - 1));

endmodule

`default_nettype wire

[sv/prcd_back.sv]
// Back part: counts matching windows per row, keeps the scan decision and
// holds the row result in an output register until it is taken.
// Depends on prcd_pkg.
`default_nettype none

module prcd_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           head_valid_i,
    input  wire prcd_pkg::entry_t               head_i,
    output logic                                pop_o,
    input  wire logic [prcd_pkg::MREQ_W-1:0]    mreq_i,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_row_changed,
    output logic                                m_decided,
    output logic                                m_tear_found,
    output logic [prcd_pkg::ROW_W-1:0]          m_tear_row
);

    localparam int MW = prcd_pkg::MREQ_W;
    localparam int RW = prcd_pkg::ROW_W;

    logic [MW-1:0] mc_reg;
    logic          dec_reg;
    logic          tear_reg;
    logic [RW-1:0] fnr_reg;
    logic          out_valid_reg;
    logic          out_changed_reg;
    logic          out_dec_reg;
    logic          out_tear_reg;
    logic [RW-1:0] out_row_reg;

    logic [MW-1:0] need;
    logic [MW-1:0] mc_inc;
    logic          changed;
    logic          dec_next;
    logic          tear_next;
    logic [RW-1:0] fnr_next;

    // A row end waits only while the output register is full and not taken.
    assign pop_o = head_valid_i && (!head_i.last || !out_valid_reg || m_ready);

    // Match count and decision update for the entry at the queue head
    always_comb begin
        need    = (mreq_i == '0) ? MW'(1) : mreq_i;
        mc_inc  = (head_i.win_match && (mc_reg != prcd_pkg::MATCH_MAX))
                  ? mc_reg + 1'b1 : mc_reg;
        changed = (mc_inc >= need);

        dec_next  = head_i.scan ? 1'b0 : dec_reg;
        tear_next = head_i.scan ? 1'b0 : tear_reg;
        fnr_next  = head_i.scan ? '0   : fnr_reg;
        if (head_i.last && changed && !dec_next) begin
            dec_next  = 1'b1;
            tear_next = !head_i.scan;
            fnr_next  = head_i.scan ? '0 : head_i.row;
        end
    end

    // Row and scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mc_reg        <= '0;
            dec_reg       <= 1'b0;
            tear_reg      <= 1'b0;
            fnr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop_o) begin
                mc_reg   <= head_i.last ? '0 : mc_inc;
                dec_reg  <= dec_next;
                tear_reg <= tear_next;
                fnr_reg  <= fnr_next;
            end
            if (pop_o && head_i.last) out_valid_reg <= 1'b1;
            else if (m_ready)         out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (pop_o && head_i.last) begin
            out_changed_reg <= changed;
            out_dec_reg     <= dec_next;
            out_tear_reg    <= tear_next;
            out_row_reg     <= tear_next ? fnr_next : '0;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_row_changed = out_changed_reg;
    assign m_decided     = out_dec_reg;
    assign m_tear_found  = out_tear_reg;
    assign m_tear_row    = out_row_reg;

endmodule

`default_nettype wire

[sv/pixel_row_change_detector_unit.sv]
// Top level of the pixel row change detector: configuration registers and
// the front part, phase unit, queue and back part. Depends on prcd_pkg.
//
//   Channel  | Direction | Handshake          | Payload
//   ---------+-----------+--------------------+-----------------------------------
//   s_       | in        | s_valid / s_ready  | new/old B,G,R, row, scan, last
//   m_       | out       | m_valid / m_ready  | row_changed, decided, tear_found/row
//   cfg_     | in        | cfg_wr_en          | cfg_index, cfg_wr_data
//
// One pixel transfer per cycle while s_ready is high; a row result passes from its
// last pixel through the stage-one register, the queue and the output register.
// A write of window_length or step_size holds s_ready low while the column
// and length phases are recomputed serially over the remainder width (max of
// column and length widths). Reset is synchronous and needs no clearing pass.
// A stalled result output backs up through the four-entry queue before s_ready drops.
`default_nettype none

module pixel_row_change_detector_unit #(
    parameter int MAX_WINDOW = prcd_pkg::MAX_WINDOW_DEF,
    parameter int MAX_WIDTH  = prcd_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [prcd_pkg::CFG_W-1:0]        cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [prcd_pkg::PIX_W-1:0]        s_new_blue,
    input  wire logic [prcd_pkg::PIX_W-1:0]        s_new_green,
    input  wire logic [prcd_pkg::PIX_W-1:0]        s_new_red,
    input  wire logic [prcd_pkg::PIX_W-1:0]        s_old_blue,
    input  wire logic [prcd_pkg::PIX_W-1:0]        s_old_green,
    input  wire logic [prcd_pkg::PIX_W-1:0]        s_old_red,
    input  wire logic [prcd_pkg::ROW_W-1:0]        s_row_index,
    input  wire logic                              s_start_of_scan,
    input  wire logic                              s_last_in_row,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_row_changed,
    output logic                                   m_decided,
    output logic                                   m_tear_found,
    output logic [prcd_pkg::ROW_W-1:0]             m_tear_row
);

    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int LENW = $clog2(MAX_WINDOW + 1);

    logic [prcd_pkg::LEN_W-1:0]  window_length_reg;
    logic [prcd_pkg::THR_W-1:0]  diff_threshold_reg;
    logic [prcd_pkg::STEP_W-1:0] step_size_reg;
    logic [prcd_pkg::MREQ_W-1:0] matches_required_reg;

    logic [LENW-1:0]             eff_len;
    logic [prcd_pkg::STEP_W-1:0] eff_step;
    logic                        cfg_touch;
    logic [CW-1:0]               col;

    prcd_pkg::col_evt_t    col_evt;
    prcd_pkg::phase_stat_t phase_stat;
    prcd_pkg::queue_stat_t q_stat;
    prcd_pkg::entry_t      push_entry;
    prcd_pkg::entry_t      head;
    logic                  push;
    logic                  pop;
    logic                  head_valid;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg    <= prcd_pkg::RESET_WINDOW_LENGTH;
            diff_threshold_reg   <= prcd_pkg::RESET_DIFF_THRESHOLD;
            step_size_reg        <= prcd_pkg::RESET_STEP_SIZE;
            matches_required_reg <= prcd_pkg::RESET_MATCHES_REQUIRED;
        end else if (cfg_wr_en) begin
            unique case (prcd_pkg::cfg_index_t'(cfg_index))
                prcd_pkg::CFG_WINDOW_LENGTH:
                    window_length_reg <= cfg_wr_data[prcd_pkg::LEN_W-1:0];
                prcd_pkg::CFG_DIFF_THRESHOLD:
                    diff_threshold_reg <= cfg_wr_data[prcd_pkg::THR_W-1:0];
                prcd_pkg::CFG_STEP_SIZE:
                    step_size_reg <= cfg_wr_data[prcd_pkg::STEP_W-1:0];
                prcd_pkg::CFG_MATCHES_REQUIRED:
                    matches_required_reg <= cfg_wr_data[prcd_pkg::MREQ_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective window length and step: zero means one, length clamps.
    always_comb begin
        if (window_length_reg == '0) begin
            eff_len = LENW'(1);
        end else if (32'(window_length_reg) > MAX_WINDOW) begin
            eff_len = LENW'(MAX_WINDOW);
        end else begin
            eff_len = LENW'(window_length_reg);
        end
        eff_step  = (step_size_reg == '0) ? prcd_pkg::STEP_W'(1) : step_size_reg;
        cfg_touch = cfg_wr_en &&
                    ((cfg_index == prcd_pkg::CFG_WINDOW_LENGTH) ||
                     (cfg_index == prcd_pkg::CFG_STEP_SIZE));
    end

    prcd_phase #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_phase (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_touch  (cfg_touch),
        .col_i      (col),
        .eff_len_i  (eff_len),
        .eff_step_i (eff_step),
        .evt_i      (col_evt),
        .stat_o     (phase_stat)
    );

    prcd_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_new_blue      (s_new_blue),
        .s_new_green     (s_new_green),
        .s_new_red       (s_new_red),
        .s_old_blue      (s_old_blue),
        .s_old_green     (s_old_green),
        .s_old_red       (s_old_red),
        .s_row_index     (s_row_index),
        .s_start_of_scan (s_start_of_scan),
        .s_last_in_row   (s_last_in_row),
        .eff_len_i       (eff_len),
        .thr_i           (diff_threshold_reg),
        .phase_stat_i    (phase_stat),
        .q_stat_i        (q_stat),
        .col_o           (col),
        .evt_o           (col_evt),
        .push_o          (push),
        .push_entry_o    (push_entry)
    );

    prcd_queue u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push_i       (push),
        .push_entry_i (push_entry),
        .pop_i        (pop),
        .head_valid_o (head_valid),
        .head_o       (head),
        .stat_o       (q_stat)
    );

    prcd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid_i  (head_valid),
        .head_i        (head),
        .pop_o         (pop),
        .mreq_i        (matches_required_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_row_changed (m_row_changed),
        .m_decided     (m_decided),
        .m_tear_found  (m_tear_found),
        .m_tear_row    (m_tear_row)
    );

endmodule

`default_nettype wire

[sv/prcd_checker.sv]
// Port-level checks on the result channel of the detector, attached to the
// top level by the bind statement below. Depends on prcd_pkg widths only.
`default_nettype none

module prcd_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic                          m_row_changed,
    input wire logic                          m_decided,
    input wire logic                          m_tear_found,
    input wire logic [prcd_pkg::ROW_W-1:0]    m_tear_row
);

    // No result is offered in the cycle after reset.
    a_idle_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered right after reset");

    // A changed row always leaves the scan decided.
    a_changed_decides: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_row_changed) |-> m_decided)
        else $error("changed row without a decision");

    // A tear is only reported once decided, and the row is zero without a tear.
    a_tear_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((!m_tear_found || m_decided) &&
                     (m_tear_found || (m_tear_row == '0))))
        else $error("inconsistent tear report");

    // A stalled result transfer holds its payload.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_row_changed) &&
            $stable(m_decided) && $stable(m_tear_found) && $stable(m_tear_row)))
        else $error("stalled result changed");

endmodule

bind pixel_row_change_detector_unit prcd_checker u_prcd_checker (.*);

`default_nettype wire

[verif/testbench.sv]
// Testbench for pixel_row_change_detector_unit: drives pixel transfers and register
// writes, and checks every row result against a scoreboard that predicts it.
// Depends on prcd_pkg and the pixel_row_change_detector_unit RTL.

module testbench;
    import prcd_pkg::*;

    localparam int WIN_CAP        = 64;
    localparam int COL_CAP        = 4096;
    localparam int TIMEOUT_CYCLES = 500000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int CALM_ITEMS     = 150;
    localparam int MIN_ROWS       = 60;
    localparam int MAX_PRINTS     = 100;

    // Row scan flag patterns for generated rows
    localparam int SCAN_NONE  = 0;
    localparam int SCAN_ALL   = 1;
    localparam int SCAN_MIXED = 2;

    typedef struct packed {
        logic [PIX_W-1:0] new_b;
        logic [PIX_W-1:0] new_g;
        logic [PIX_W-1:0] new_r;
        logic [PIX_W-1:0] old_b;
        logic [PIX_W-1:0] old_g;
        logic [PIX_W-1:0] old_r;
        logic [ROW_W-1:0] row;
        logic             scan;
        logic             last;
    } pixel_t;

    typedef struct packed {
        logic             changed;
        logic             decided;
        logic             tear;
        logic [ROW_W-1:0] tear_row;
    } row_result_t;

    // Predicts the row results from accepted pixels and checks the results that arrive.
    class row_scoreboard;
        logic [LEN_W-1:0]  win_len  = RESET_WINDOW_LENGTH;
        logic [THR_W-1:0]  thr      = RESET_DIFF_THRESHOLD;
        logic [STEP_W-1:0] step_reg = RESET_STEP_SIZE;
        logic [MREQ_W-1:0] need_reg = RESET_MATCHES_REQUIRED;

        int          diff_line [WIN_CAP][3];
        int unsigned col_cnt;
        int unsigned match_cnt;
        bit          decided_f;
        bit          tear_f;
        logic [ROW_W-1:0] first_row;

        row_result_t rows_due [$];
        int          errors;
        int          prints;

        task report_mismatch(string msg);
            errors++;
            if (prints < MAX_PRINTS) begin
                prints++;
                $display("MISMATCH at %0t: %s", $realtime, msg);
            end
        endtask

        function void set_reg(cfg_index_t idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_WINDOW_LENGTH:    win_len  = data[LEN_W-1:0];
                CFG_DIFF_THRESHOLD:   thr      = data[THR_W-1:0];
                CFG_STEP_SIZE:        step_reg = data[STEP_W-1:0];
                CFG_MATCHES_REQUIRED: need_reg = data[MREQ_W-1:0];
                default: ;
            endcase
        endfunction

        // Judges the window of len columns that ends just before the current column.
        function bit window_hit(int unsigned len);
            int          sums [3];
            int          limit;
            int          mag;
            int unsigned k;
            int unsigned slot;
            for (int ch = 0; ch < 3; ch++) sums[ch] = 0;
            limit = len * thr;
            for (k = 1; k <= len; k++) begin
                slot = (col_cnt - k) % WIN_CAP;
                for (int ch = 0; ch < 3; ch++) sums[ch] += diff_line[slot][ch];
            end
            for (int ch = 0; ch < 3; ch++) begin
                mag = (sums[ch] < 0) ? -sums[ch] : sums[ch];
                if (mag > limit) return 1'b1;
            end
            return 1'b0;
        endfunction

        // Notes one accepted pixel transfer; a row's last pixel queues its result.
        function void note_pixel(pixel_t px);
            int unsigned len;
            int unsigned step;
            int unsigned need;
            bit          changed;
            row_result_t due;
            len  = (win_len == 0) ? 1 : ((win_len > WIN_CAP) ? WIN_CAP : win_len);
            step = (step_reg == 0) ? 1 : step_reg;
            need = (need_reg == 0) ? 1 : need_reg;

            if (px.scan) begin
                decided_f = 1'b0;
                tear_f    = 1'b0;
                first_row = '0;
            end

            // Columns past the row capacity complete no window and store nothing.
            if (col_cnt < COL_CAP) begin
                if (col_cnt >= len && ((col_cnt - len) % step) == 0) begin
                    if (window_hit(len) && match_cnt < MATCH_MAX) match_cnt++;
                end
                diff_line[col_cnt % WIN_CAP][0] = int'(px.new_b) - int'(px.old_b);
                diff_line[col_cnt % WIN_CAP][1] = int'(px.new_g) - int'(px.old_g);
                diff_line[col_cnt % WIN_CAP][2] = int'(px.new_r) - int'(px.old_r);
                col_cnt++;
            end

            if (px.last) begin
                changed = (match_cnt >= need);
                if (changed && !decided_f) begin
                    decided_f = 1'b1;
                    if (!px.scan) begin
                        tear_f    = 1'b1;
                        first_row = px.row;
                    end else begin
                        first_row = '0;
                    end
                end
                due.changed  = changed;
                due.decided  = decided_f;
                due.tear     = tear_f;
                due.tear_row = tear_f ? first_row : '0;
                rows_due.push_back(due);
                col_cnt   = 0;
                match_cnt = 0;
            end
        endfunction

        // Compares one result transfer with the oldest pending row result.
        task check_row(row_result_t got);
            row_result_t due;
            if (rows_due.size() == 0) begin
                report_mismatch($sformatf("unexpected row result changed=%0b decided=%0b tear=%0b row=%0d",
                    got.changed, got.decided, got.tear, got.tear_row));
            end else begin
                due = rows_due.pop_front();
                if (got !== due) begin
                    report_mismatch($sformatf(
                        "row result changed=%0b decided=%0b tear=%0b row=%0d, want %0b %0b %0b %0d",
                        got.changed, got.decided, got.tear, got.tear_row,
                        due.changed, due.decided, due.tear, due.tear_row));
                end
            end
        endtask

        function int pending();
            return rows_due.size();
        endfunction

        // Any row result still pending at the end never arrived.
        task flush_check();
            row_result_t due;
            while (rows_due.size() != 0) begin
                due = rows_due.pop_front();
                report_mismatch($sformatf("missing row result changed=%0b decided=%0b tear=%0b row=%0d",
                    due.changed, due.decided, due.tear, due.tear_row));
            end
        endtask
    endclass

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    cfg_index_t        cfg_index   = CFG_WINDOW_LENGTH;
    logic [CFG_W-1:0]  cfg_wr_data = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    pixel_t            s_px        = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic              m_row_changed;
    logic              m_decided;
    logic              m_tear_found;
    logic [ROW_W-1:0]  m_tear_row;

    row_scoreboard     sb;
    row_result_t       got_row;
    bit                calm;
    int                stall_left;
    int                items_sent;
    int                rows_sent;
    int unsigned       cycles;

    pixel_row_change_detector_unit u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_new_blue      (s_px.new_b),
        .s_new_green     (s_px.new_g),
        .s_new_red       (s_px.new_r),
        .s_old_blue      (s_px.old_b),
        .s_old_green     (s_px.old_g),
        .s_old_red       (s_px.old_r),
        .s_row_index     (s_px.row),
        .s_start_of_scan (s_px.scan),
        .s_last_in_row   (s_px.last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_row_changed   (m_row_changed),
        .m_decided       (m_decided),
        .m_tear_found    (m_tear_found),
        .m_tear_row      (m_tear_row)
    );

    always #5 aclk = ~aclk;

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == TIMEOUT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Sample both channels at the edge where a transfer completes.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_pixel(s_px);
        if (aresetn && m_valid && m_ready) begin
            got_row = '{m_row_changed, m_decided, m_tear_found, m_tear_row};
            sb.check_row(got_row);
        end
    end

    // Result side stalls in random bursts, except in the calm part of the run.
    always @(posedge aclk) begin
        if (calm) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 16) - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Offers one pixel, possibly after an idle burst, and waits for its transfer.
    task send_pixel(pixel_t px);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_px    <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Lets every pending row result come out, then lets the pipeline settle.
    task wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write; the caller lowers the write enable after the last one.
    task put_reg(cfg_index_t idx, logic [CFG_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        sb.set_reg(idx, data);
    endtask

    task write_config(logic [CFG_W-1:0] wl, logic [CFG_W-1:0] th,
                      logic [CFG_W-1:0] st, logic [CFG_W-1:0] mr);
        put_reg(CFG_WINDOW_LENGTH, wl);
        put_reg(CFG_DIFF_THRESHOLD, th);
        put_reg(CFG_STEP_SIZE, st);
        put_reg(CFG_MATCHES_REQUIRED, mr);
        cfg_wr_en <= 1'b0;
    endtask

    // Picks a register setting, leaning on small windows but reaching every extreme.
    task random_config();
        logic [CFG_W-1:0] wl;
        logic [CFG_W-1:0] th;
        logic [CFG_W-1:0] st;
        logic [CFG_W-1:0] mr;
        case ($urandom_range(0, 9))
            0: wl = 0;
            1: wl = WIN_CAP;
            2: wl = $urandom_range(WIN_CAP + 1, 127);
            3: wl = $urandom_range(1, 127);
            default: wl = $urandom_range(1, 10);
        endcase
        case ($urandom_range(0, 9))
            0: th = 0;
            1: th = 255;
            2: th = $urandom_range(0, 255);
            default: th = $urandom_range(0, 8);
        endcase
        case ($urandom_range(0, 9))
            0: st = 0;
            1: st = WIN_CAP;
            2: st = 127;
            3: st = $urandom_range(1, 127);
            default: st = $urandom_range(1, 4);
        endcase
        case ($urandom_range(0, 9))
            0: mr = 0;
            1: mr = MATCH_MAX;
            2: mr = $urandom_range(0, MATCH_MAX);
            default: mr = $urandom_range(1, 6);
        endcase
        // Bits above a register's width are don't-care; drive them sometimes.
        if ($urandom_range(0, 3) == 0) wl[CFG_W-1:LEN_W] = $urandom;
        if ($urandom_range(0, 3) == 0) th[CFG_W-1:THR_W] = $urandom;
        if ($urandom_range(0, 3) == 0) st[CFG_W-1:STEP_W] = $urandom;
        write_config(wl, th, st, mr);
    endtask

    // Sends one row of pixels. A negative spread gives unrelated frames; otherwise the
    // new pixel is the old one moved by up to spread, over the whole row or one segment.
    task send_row(int width, logic [ROW_W-1:0] row, int scan_mode, int spread, bit ends);
        int     seg_lo;
        int     seg_hi;
        int     v;
        int     o [3];
        int     n [3];
        pixel_t px;
        if ($urandom_range(0, 1) == 0) begin
            seg_lo = 0;
            seg_hi = width;
        end else begin
            seg_lo = $urandom_range(0, width - 1);
            seg_hi = $urandom_range(seg_lo + 1, width);
        end
        for (int c = 0; c < width; c++) begin
            for (int ch = 0; ch < 3; ch++) begin
                o[ch] = $urandom_range(0, 255);
                if (spread < 0) begin
                    n[ch] = $urandom_range(0, 255);
                end else if (c >= seg_lo && c < seg_hi) begin
                    v = o[ch] + int'($urandom_range(0, 2 * spread)) - spread;
                    n[ch] = (v < 0) ? 0 : ((v > 255) ? 255 : v);
                end else begin
                    n[ch] = o[ch];
                end
            end
            px.new_b = n[0];
            px.new_g = n[1];
            px.new_r = n[2];
            px.old_b = o[0];
            px.old_g = o[1];
            px.old_r = o[2];
            px.row   = row;
            px.scan  = (scan_mode == SCAN_ALL) ||
                       (scan_mode == SCAN_MIXED && $urandom_range(0, 3) == 0);
            px.last  = ends && (c == width - 1);
            send_pixel(px);
        end
        if (ends) rows_sent++;
    endtask

    // One scan: a start row followed by rows in order, with some broken rows mixed in.
    task run_scan(int rows);
        logic [ROW_W-1:0] row;
        int               width;
        int               spread;
        int               scan_mode;
        bit               ends;
        row = $urandom;
        for (int i = 0; i < rows; i++) begin
            width = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 260) : $urandom_range(1, 32);
            case ($urandom_range(0, 9))
                0, 1, 2:    spread = 0;
                3, 4, 5, 6: spread = $urandom_range(0, sb.thr + 4);
                7, 8:       spread = $urandom_range(0, 255);
                default:    spread = -1;
            endcase
            scan_mode = (i == 0) ? SCAN_ALL : SCAN_NONE;
            if ($urandom_range(0, 9) == 0) scan_mode = SCAN_MIXED;
            ends = ($urandom_range(0, 19) != 0);
            send_row(width, row, scan_mode, spread, ends);
            row = row + 1;
        end
    endtask

    initial begin
        int     start_items;
        pixel_t px;
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: 19 columns give exactly the 11 windows needed for a change.
        for (int c = 0; c < 19; c++) begin
            px = '{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 12'd100, 1'b1, 1'b0};
            px.last = (c == 18);
            send_pixel(px);
        end

        // Zero window, threshold, step and matches; opposite extremes per channel.
        wait_idle();
        write_config(0, 0, 0, 0);
        send_pixel('{8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd128, 12'd10, 1'b1, 1'b0});
        send_pixel('{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 12'd10, 1'b1, 1'b0});
        send_pixel('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 12'd10, 1'b1, 1'b1});
        send_pixel('{8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 12'd11, 1'b0, 1'b0});
        send_pixel('{8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 12'd11, 1'b0, 1'b1});

        // Window length above the cap, with junk in the upper data bits; the scan flag
        // on the first pixel only clears the decision.
        wait_idle();
        write_config({6'h3F, 7'd127}, 254, 127, 1);
        send_pixel('{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 12'd13, 1'b1, 1'b0});
        send_pixel('{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 12'd13, 1'b0, 1'b0});
        send_pixel('{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 12'd13, 1'b0, 1'b1});

        // First changed row outside a start row is a tear, at the highest row index.
        wait_idle();
        write_config(1, 254, 1, 1);
        send_pixel('{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 12'd4095, 1'b0, 1'b0});
        send_pixel('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 12'd4095, 1'b0, 1'b1});

        // Register write in the middle of a row, with the largest threshold and count.
        send_pixel('{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 12'd7, 1'b0, 1'b0});
        send_pixel('{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 12'd7, 1'b0, 1'b0});
        wait_idle();
        write_config(2, 255, 2, MATCH_MAX);
        send_pixel('{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 12'd7, 1'b0, 1'b1});

        // A row longer than the column capacity: columns past it must not add matches.
        wait_idle();
        write_config(1, 0, 1, COL_CAP);
        for (int c = 0; c < COL_CAP + 8; c++) begin
            px = '{8'd200, 8'd0, 8'd0, 8'd10, 8'd0, 8'd0, 12'd2048, 1'b1, 1'b0};
            px.new_g = $urandom;
            px.old_g = $urandom;
            px.last  = (c == COL_CAP + 7);
            send_pixel(px);
        end

        // Random scans under random settings; the tail runs without idle bursts or result stalls.
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS || rows_sent < MIN_ROWS) begin
            if (items_sent - start_items >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            wait_idle();
            random_config();
            repeat ($urandom_range(1, 3)) run_scan($urandom_range(1, 5));
        end

        wait_idle();
        sb.flush_check();
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[sim.f]
sv/prcd_pkg.sv
sv/prcd_phase.sv
sv/prcd_front.sv
sv/prcd_queue.sv
sv/prcd_back.sv
sv/pixel_row_change_detector_unit.sv
sv/prcd_checker.sv
verif/testbench.sv
